### rtl/fra_pkg.sv
`default_nettype none
package fra_pkg;

	// result status codes
	localparam logic [1:0] ST_PROPER = 2'd0;
	localparam logic [1:0] ST_WHOLE  = 2'd1;
	localparam logic [1:0] ST_UNDEF  = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;       // latch request operands
		logic mul0;       // product yn*zd
		logic mul1;       // n = product, product zn*yd
		logic mul2;       // n += product, product yd*zd
		logic mul3;       // d = product
		logic chk;        // flag zero denominator, seed gcd
		logic gcd_step;   // one binary gcd step
		logic gcd_fin;    // latch gcd, start numerator division
		logic div_step;   // one restoring division bit
		logic div_ld_den; // store numerator quotient, start denominator division
		logic out_wr;     // load output register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic d_zero;
		logic a_zero;
	} stat_t;

endpackage
`default_nettype wire

### rtl/fra_ctrl.sv
`default_nettype none
module fra_ctrl #(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          in_cmd,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire fra_pkg::stat_t stat,
	output fra_pkg::cmd_t      cmd_o
);

	localparam int NW = 2 * OPERAND_WIDTH + 1;
	localparam int CW = $clog2(NW);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_MUL0  = 11'b000_0000_0010,
		S_MUL1  = 11'b000_0000_0100,
		S_MUL2  = 11'b000_0000_1000,
		S_MUL3  = 11'b000_0001_0000,
		S_CHK   = 11'b000_0010_0000,
		S_GCD   = 11'b000_0100_0000,
		S_DIVN  = 11'b000_1000_0000,
		S_DIVDL = 11'b001_0000_0000,
		S_DIVD  = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic            out_valid_q;
	logic            last_bit;
	logic            out_free;

	assign last_bit  = (cnt_q == CW'(NW - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd_o   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_o.load = 1'b1;
					state_d    = in_cmd ? S_MUL0 : S_CHK;
				end
			end
			S_MUL0: begin
				cmd_o.mul0 = 1'b1;
				state_d    = S_MUL1;
			end
			S_MUL1: begin
				cmd_o.mul1 = 1'b1;
				state_d    = S_MUL2;
			end
			S_MUL2: begin
				cmd_o.mul2 = 1'b1;
				state_d    = S_MUL3;
			end
			S_MUL3: begin
				cmd_o.mul3 = 1'b1;
				state_d    = S_CHK;
			end
			S_CHK: begin
				cmd_o.chk = 1'b1;
				state_d   = stat.d_zero ? S_DONE : S_GCD;
			end
			S_GCD: begin
				if (stat.a_zero) begin
					cmd_o.gcd_fin = 1'b1;
					cnt_d         = '0;
					state_d       = S_DIVN;
				end else begin
					cmd_o.gcd_step = 1'b1;
				end
			end
			S_DIVN: begin
				cmd_o.div_step = 1'b1;
				cnt_d          = cnt_q + CW'(1);
				if (last_bit) begin
					state_d = S_DIVDL;
				end
			end
			S_DIVDL: begin
				cmd_o.div_ld_den = 1'b1;
				cnt_d            = '0;
				state_d          = S_DIVD;
			end
			S_DIVD: begin
				cmd_o.div_step = 1'b1;
				cnt_d          = cnt_q + CW'(1);
				if (last_bit) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd_o.out_wr = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd_o.out_wr) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/fra_dp.sv
`default_nettype none
module fra_dp #(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic                       clk,
	input  wire logic [OPERAND_WIDTH-1:0]   first_num,
	input  wire logic [OPERAND_WIDTH-1:0]   first_den,
	input  wire logic [OPERAND_WIDTH-1:0]   second_num,
	input  wire logic [OPERAND_WIDTH-1:0]   second_den,
	input  wire fra_pkg::cmd_t              cmd_i,
	output fra_pkg::stat_t                  stat,
	output logic [2*OPERAND_WIDTH:0]        sum_num,
	output logic [2*OPERAND_WIDTH-1:0]      sum_den,
	output logic [2*OPERAND_WIDTH:0]        reduced_num,
	output logic [2*OPERAND_WIDTH-1:0]      reduced_den,
	output logic [1:0]                      status
);

	localparam int W  = OPERAND_WIDTH;
	localparam int NW = 2 * W + 1;
	localparam int DW = 2 * W;
	localparam int KW = $clog2(NW);

	// operands and unreduced pair
	logic [W-1:0]  yn_q, yd_q, zn_q, zd_q;
	logic [DW-1:0] prod_q;
	logic [NW-1:0] n_q;
	logic [DW-1:0] d_q;
	logic          undef_q;

	// gcd state
	logic [NW-1:0] a_q;
	logic [DW-1:0] b_q;
	logic [KW-1:0] k_q;
	logic [DW-1:0] g_q;

	// divider state
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] rn_q;

	logic [W-1:0]  mul_a, mul_b;
	logic [DW-1:0] mul_p;
	logic [NW-1:0] b_ext;
	logic          a_ge_b;
	logic [NW-1:0] a_minus_b;
	logic [NW-1:0] b_minus_a;
	logic [DW:0]   rem_sh;
	logic          rem_ge;
	logic [DW:0]   rem_sub;
	logic [DW-1:0] rd_w;

	assign stat.d_zero = (d_q == '0);
	assign stat.a_zero = (a_q == '0);

	// shared multiplier operand select
	always_comb begin
		mul_a = yn_q;
		mul_b = zd_q;
		if (cmd_i.mul1) begin
			mul_a = zn_q;
			mul_b = yd_q;
		end else if (cmd_i.mul2) begin
			mul_a = yd_q;
			mul_b = zd_q;
		end
	end
	assign mul_p = DW'(mul_a) * DW'(mul_b);

	// binary gcd step terms
	assign b_ext     = NW'(b_q);
	assign a_ge_b    = (a_q >= b_ext);
	assign a_minus_b = a_q - b_ext;
	assign b_minus_a = b_ext - a_q;

	// restoring divider step terms
	assign rem_sh  = {rem_q, quo_q[NW-1]};
	assign rem_ge  = (rem_sh >= {1'b0, g_q});
	assign rem_sub = rem_sh - {1'b0, g_q};

	assign rd_w = quo_q[DW-1:0];

	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			yn_q <= first_num;
			yd_q <= first_den;
			zn_q <= second_num;
			zd_q <= second_den;
			n_q  <= NW'(first_num);
			d_q  <= DW'(first_den);
		end
		if (cmd_i.mul0 || cmd_i.mul1 || cmd_i.mul2) begin
			prod_q <= mul_p;
		end
		if (cmd_i.mul1) begin
			n_q <= NW'(prod_q);
		end
		if (cmd_i.mul2) begin
			n_q <= n_q + NW'(prod_q);
		end
		if (cmd_i.mul3) begin
			d_q <= prod_q;
		end

		// seed gcd with the unreduced pair
		if (cmd_i.chk) begin
			undef_q <= stat.d_zero;
			a_q     <= n_q;
			b_q     <= d_q;
			k_q     <= '0;
		end

		// one gcd step: strip common twos, strip lone twos, subtract
		if (cmd_i.gcd_step) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_ge_b) begin
				a_q <= a_minus_b >> 1;
			end else begin
				b_q <= DW'(b_minus_a >> 1);
			end
		end

		if (cmd_i.gcd_fin) begin
			g_q   <= b_q << k_q;
			quo_q <= n_q;
			rem_q <= '0;
		end

		if (cmd_i.div_step) begin
			if (rem_ge) begin
				rem_q <= rem_sub[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end

		if (cmd_i.div_ld_den) begin
			rn_q  <= quo_q;
			quo_q <= NW'(d_q);
			rem_q <= '0;
		end

		// output register
		if (cmd_i.out_wr) begin
			sum_num <= n_q;
			sum_den <= d_q;
			if (undef_q) begin
				reduced_num <= '0;
				reduced_den <= '0;
				status      <= fra_pkg::ST_UNDEF;
			end else begin
				reduced_num <= rn_q;
				reduced_den <= rd_w;
				status      <= (rd_w == DW'(1)) ? fra_pkg::ST_WHOLE : fra_pkg::ST_PROPER;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/fraction_add_and_reduce.sv
// Sequence: load, the multiply steps mul0 to mul3 in add mode only, a check, the
// binary gcd loop, then two bit-serial restoring divisions by the gcd (numerator first,
// then denominator), with a handoff step before each division.
// A zero denominator skips the gcd and divisions and goes straight to the output.
// Throughput: one request at a time, set by the gcd loop and the shared divider.
// Reset: arst_n asynchronous, clears the controller and the output valid.
`default_nettype none
module fraction_add_and_reduce #(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       cmd,
	input  wire logic [OPERAND_WIDTH-1:0]   first_num,
	input  wire logic [OPERAND_WIDTH-1:0]   first_den,
	input  wire logic [OPERAND_WIDTH-1:0]   second_num,
	input  wire logic [OPERAND_WIDTH-1:0]   second_den,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [2*OPERAND_WIDTH:0]        sum_num,
	output logic [2*OPERAND_WIDTH-1:0]      sum_den,
	output logic [2*OPERAND_WIDTH:0]        reduced_num,
	output logic [2*OPERAND_WIDTH-1:0]      reduced_den,
	output logic [1:0]                      status
);

	fra_pkg::cmd_t  ctl_cmd;
	fra_pkg::stat_t dp_stat;

	// sequencer
	fra_ctrl #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_cmd    (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (dp_stat),
		.cmd_o     (ctl_cmd)
	);

	// multiply, gcd and divide datapath
	fra_dp #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_dp (
		.clk         (clk),
		.first_num   (first_num),
		.first_den   (first_den),
		.second_num  (second_num),
		.second_den  (second_den),
		.cmd_i       (ctl_cmd),
		.stat        (dp_stat),
		.sum_num     (sum_num),
		.sum_den     (sum_den),
		.reduced_num (reduced_num),
		.reduced_den (reduced_den),
		.status      (status)
	);

endmodule
`default_nettype wire
